### sv/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the structure table framer
// Phase codes, record kinds, the result word layout and parameter defaults.
// ----------------------------------------------------------------------------
package sfr_pkg;

    // Default buffer size in bytes and the end-of-table structure type
    localparam longint unsigned TABLE_BYTES_DEF = 64'd65536;
    localparam logic [7:0]      END_TYPE_DEF    = 8'd127;

    // Header size and the header byte that carries the handle high byte
    localparam logic [7:0] HDR_BYTES = 8'd4;
    localparam logic [7:0] HDR_LAST  = 8'd3;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_FORMAT  = 2'd1,
        PH_STRINGS = 2'd2,
        PH_DONE    = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_FRAMED    = 2'd0,
        KIND_END       = 2'd1,
        KIND_MALFORMED = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  stype;
        logic [7:0]  flen;
        logic [15:0] handle;
        logic [15:0] offset;
        logic [15:0] slen;
        logic        done;
    } result_t;

endpackage

### sv/smbios_structure_framer_top.sv
// ----------------------------------------------------------------------------
// smbios_structure_framer_top: SMBIOS structure table framer
// Frames header, formatted area and string set of each structure in a
// byte stream and reports one record per structure or table end.
//
//   channel | valid / stall         | words
//   --------+-----------------------+------------------------------------------
//   item    | item_valid/item_stall | table_byte, last_byte
//   rec     | rec_valid/rec_stall   | record_kind .. table_done (one record)
//
// One byte enters per cycle while item_stall is low; a record is offered
// from the result register after its byte has passed the input register.
// The input register and the result register sit around the framing
// logic, which builds each record word combinationally.
// rst_n clears the framer to header phase at table offset zero.
// A stalled record holds the framer; the input register can still take
// one more byte if it is empty, then item_stall rises.
// ----------------------------------------------------------------------------
module smbios_structure_framer_top
    import sfr_pkg::*;
#(
    parameter longint unsigned TABLE_BYTES = TABLE_BYTES_DEF,
    parameter logic [7:0]      END_TYPE    = END_TYPE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [7:0]  table_byte,
    input  logic        last_byte,
    output logic        rec_valid,
    input  logic        rec_stall,
    output logic [1:0]  record_kind,
    output logic [7:0]  struct_type,
    output logic [7:0]  formatted_length,
    output logic [15:0] struct_handle,
    output logic [15:0] struct_offset,
    output logic [15:0] strings_length,
    output logic        table_done
);

    logic       held_valid;
    logic [7:0] held_byte;
    logic       held_last;
    logic       advance;
    logic       res_valid;
    result_t    res;
    result_t    rec;

    // Advance the framer when a byte waits and the result slot is free
    assign advance = held_valid && (!rec_valid || !rec_stall);

    sfr_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .table_byte (table_byte),
        .last_byte  (last_byte),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte),
        .held_last  (held_last)
    );

    sfr_core #(
        .TABLE_BYTES (TABLE_BYTES),
        .END_TYPE    (END_TYPE)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .in_byte   (held_byte),
        .in_last   (held_last),
        .res_valid (res_valid),
        .res       (res)
    );

    sfr_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .rec_stall (rec_stall),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    // Split the record word onto its ports
    assign record_kind      = rec.kind;
    assign struct_type      = rec.stype;
    assign formatted_length = rec.flen;
    assign struct_handle    = rec.handle;
    assign struct_offset    = rec.offset;
    assign strings_length   = rec.slen;
    assign table_done       = rec.done;

endmodule

### sv/sfr_in_reg.sv
// ----------------------------------------------------------------------------
// sfr_in_reg: input register for table bytes
// Captures one byte word and its last mark; stalls the source while full
// and the framer cannot advance.
// ----------------------------------------------------------------------------
module sfr_in_reg
    import sfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [7:0] table_byte,
    input  logic       last_byte,
    input  logic       advance,
    output logic       held_valid,
    output logic [7:0] held_byte,
    output logic       held_last
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       accept;

    // Stall only while a word waits that the framer does not take
    assign item_stall = valid_reg && !advance;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // Hold the control bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= table_byte;
            last_reg <= last_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;
    assign held_last  = last_reg;

endmodule

### sv/sfr_core.sv
// ----------------------------------------------------------------------------
// sfr_core: framing state machine
// Tracks header, formatted area and string set, one byte per step, and
// decides the record that a byte produces.
// ----------------------------------------------------------------------------
module sfr_core
    import sfr_pkg::*;
#(
    parameter longint unsigned TABLE_BYTES = TABLE_BYTES_DEF,
    parameter logic [7:0]      END_TYPE    = END_TYPE_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       res_valid,
    output result_t    res
);

    localparam int OFF_W = $clog2(TABLE_BYTES);
    localparam int EXT_W = (OFF_W > 16) ? OFF_W : 16;
    localparam logic [OFF_W-1:0] LAST_OFF = OFF_W'(TABLE_BYTES - 64'd1);

    phase_t             phase_reg,  phase_next;
    logic [7:0]         bis_reg,    bis_next;
    logic [7:0]         type_reg,   type_next;
    logic [7:0]         len_reg,    len_next;
    logic [15:0]        handle_reg, handle_next;
    logic [OFF_W-1:0]   offset_reg, offset_next;
    logic [15:0]        start_reg,  start_next;
    logic [15:0]        scount_reg, scount_next;
    logic               pzero_reg,  pzero_next;

    logic [EXT_W-1:0]   off_ext;
    logic               last;
    logic               emit;
    logic               ended;
    kind_t              kind;
    logic               done_flag;
    logic [15:0]        sc_inc;
    logic [7:0]         bis_inc;

    // Current byte values merged with the header fields held so far
    always_comb
    begin
        off_ext     = EXT_W'(offset_reg);
        last        = in_last || (offset_reg == LAST_OFF);
        bis_inc     = bis_reg + 8'd1;
        sc_inc      = (scount_reg == 16'hFFFF) ? scount_reg : scount_reg + 16'd1;
        start_next  = start_reg;
        type_next   = type_reg;
        len_next    = len_reg;
        handle_next = handle_reg;
        if (phase_reg == PH_HEADER)
        begin
            unique case (bis_reg)
                8'd0:
                begin
                    start_next = off_ext[15:0];
                    type_next  = in_byte;
                end
                8'd1:    len_next    = in_byte;
                8'd2:    handle_next = {8'h00, in_byte};
                default: handle_next = {in_byte, handle_reg[7:0]};
            endcase
        end
    end

    // Decide whether this byte produces a record and ends the table
    always_comb
    begin
        emit      = 1'b0;
        ended     = 1'b0;
        kind      = KIND_END;
        done_flag = 1'b1;
        unique case (phase_reg)
            PH_HEADER:
            begin
                if (bis_reg < HDR_LAST)
                begin
                    if (last)
                    begin
                        emit  = 1'b1;
                        ended = 1'b1;
                        kind  = KIND_END;
                    end
                end
                else if (type_next == 8'd0 && len_next == 8'd0)
                begin
                    emit  = 1'b1;
                    ended = 1'b1;
                    kind  = KIND_END;
                end
                else if (len_next < HDR_BYTES || last)
                begin
                    emit  = 1'b1;
                    ended = 1'b1;
                    kind  = KIND_MALFORMED;
                end
            end
            PH_FORMAT:
            begin
                if (last)
                begin
                    emit  = 1'b1;
                    ended = 1'b1;
                    kind  = KIND_MALFORMED;
                end
            end
            PH_STRINGS:
            begin
                if (in_byte == 8'd0 && (pzero_reg || last))
                begin
                    emit      = 1'b1;
                    kind      = KIND_FRAMED;
                    done_flag = last || (type_reg == END_TYPE);
                    ended     = done_flag;
                end
                else if (last)
                begin
                    emit  = 1'b1;
                    ended = 1'b1;
                    kind  = KIND_MALFORMED;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Next phase and counters
    always_comb
    begin
        phase_next  = phase_reg;
        bis_next    = bis_reg;
        scount_next = scount_reg;
        pzero_next  = pzero_reg;
        unique case (phase_reg)
            PH_HEADER:
            begin
                if (bis_reg < HDR_LAST)
                begin
                    if (!last)
                    begin
                        bis_next = bis_inc;
                    end
                end
                else if (!emit)
                begin
                    if (len_next == HDR_BYTES)
                    begin
                        phase_next  = PH_STRINGS;
                        scount_next = 16'd0;
                        pzero_next  = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_FORMAT;
                        bis_next   = HDR_BYTES;
                    end
                end
            end
            PH_FORMAT:
            begin
                if (!last)
                begin
                    bis_next = bis_inc;
                    if (bis_inc >= len_reg)
                    begin
                        phase_next  = PH_STRINGS;
                        scount_next = 16'd0;
                        pzero_next  = 1'b0;
                    end
                end
            end
            PH_STRINGS:
            begin
                scount_next = sc_inc;
                if (emit && !ended)
                begin
                    phase_next = PH_HEADER;
                    bis_next   = 8'd0;
                end
                else if (!emit)
                begin
                    pzero_next = (in_byte == 8'd0);
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        // Re-arm on the last byte, otherwise park after the end
        if (last)
        begin
            phase_next  = PH_HEADER;
            bis_next    = 8'd0;
            scount_next = 16'd0;
            pzero_next  = 1'b0;
            offset_next = '0;
        end
        else
        begin
            if (ended)
            begin
                phase_next = PH_DONE;
            end
            offset_next = offset_reg + OFF_W'(1);
        end
    end

    // Build the record word
    always_comb
    begin
        res_valid  = step && emit;
        res.kind   = kind;
        res.offset = start_next;
        res.done   = done_flag;
        if (kind == KIND_FRAMED)
        begin
            res.stype  = type_reg;
            res.flen   = len_reg;
            res.handle = handle_reg;
            res.slen   = sc_inc;
        end
        else
        begin
            res.stype  = 8'd0;
            res.flen   = 8'd0;
            res.handle = 16'd0;
            res.slen   = 16'd0;
        end
    end

    // Advance state on each processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            bis_reg    <= 8'd0;
            type_reg   <= 8'd0;
            len_reg    <= 8'd0;
            handle_reg <= 16'd0;
            offset_reg <= '0;
            start_reg  <= 16'd0;
            scount_reg <= 16'd0;
            pzero_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            bis_reg    <= bis_next;
            type_reg   <= type_next;
            len_reg    <= len_next;
            handle_reg <= handle_next;
            offset_reg <= offset_next;
            start_reg  <= start_next;
            scount_reg <= scount_next;
            pzero_reg  <= pzero_next;
        end
    end

    // A last byte always leaves the framer at the top of a fresh table
    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        step && last |=> phase_reg == PH_HEADER && offset_reg == '0 && bis_reg == 8'd0)
        else $error("framer not re-armed after last byte");

    // End and malformed records always close the table
    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind != KIND_FRAMED |-> done_flag)
        else $error("non-structure record without table_done");

    // The formatted-area counter stays between header end and length
    a_fmt: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_FORMAT |-> bis_reg >= HDR_BYTES && bis_reg < len_reg)
        else $error("formatted-area counter out of range");

endmodule

### sv/sfr_out_reg.sv
// ----------------------------------------------------------------------------
// sfr_out_reg: result register
// Holds one record word until the sink takes it.
// ----------------------------------------------------------------------------
module sfr_out_reg
    import sfr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    input  logic    rec_stall,
    output logic    rec_valid,
    output result_t rec
);

    logic    valid_reg;
    logic    valid_next;
    result_t rec_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!rec_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture a new record
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg <= res;
        end
    end

    assign rec_valid = valid_reg;
    assign rec       = rec_reg;

endmodule
